// ===== rtl/bf_pkg.sv =====
// Shared constants, types and command/status structs for the shortest-paths unit.
package bf_pkg;

	localparam int MAX_VERTICES  = 16;
	localparam int VIDX_BITS     = 4;
	localparam int CNT_BITS      = 5;
	localparam int WEIGHT_BITS   = 16;
	localparam int DIST_BITS     = 24;
	localparam int MAT_DEPTH     = MAX_VERTICES * MAX_VERTICES;
	localparam int MAT_ADDR_BITS = 2 * VIDX_BITS;

	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_VERTEX   = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_VERTICES_IN_USE = CFG_IDX_BITS'(1);

	localparam int IN_DATA_BITS  = 24;
	localparam int OUT_DATA_BITS = 40;

	typedef logic [VIDX_BITS-1:0]          vidx_t;
	typedef logic signed [WEIGHT_BITS-1:0] weight_t;
	typedef logic signed [DIST_BITS-1:0]   dist_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic  load_entry; // store the accepted matrix entry
		logic  init;       // clear reached flags, seed the source
		logic  load_row;   // latch distance and reached flag of row vertex
		logic  issue;      // read one matrix entry for relaxation
		logic  emit;       // load one result into the output register
		logic  emit_last;  // result belongs to the final vertex
		logic  src_ok;     // source lies inside the vertices in use
		vidx_t vtx;        // row vertex, or vertex of the result
		vidx_t col;        // column vertex of the issued entry
		vidx_t src;        // source vertex
	} bf_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_ready; // output register can take a result this cycle
	} bf_status_t;

endpackage

// ===== rtl/bellman_ford_shortest_paths_unit.sv =====
// Top level of the single-source shortest-paths unit over a loaded adjacency matrix.
// Matrix entries load at one transaction per cycle while idle. The transaction with
// tlast set stores its entry and starts a run: an init step, then (V-1) passes of V
// rows, each row issuing its V entries at one relaxation step per cycle in the shared
// relax unit, fed by the single read port of the matrix RAM, followed by a drain step
// to finish the last step of the row, then V results at one per cycle when the output
// side keeps up. V is vertices_in_use after clamping to 1..16. No input is taken from
// the tlast transaction until the last result of the run has entered the output
// register; that result may still be waiting there when loads resume. The matrix keeps
// its contents across runs and reads as no edge until written after reset.
module bellman_ford_shortest_paths_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [bf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// row[3:0], col[7:4], weight[23:8]
	input  logic [bf_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// vertex[3:0], reachable[4], distance[28:5], has_parent[29], parent[33:30], zeros
	output logic [bf_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
	output logic                              m_axis_tlast
);

	import bf_pkg::*;

	bf_cmd_t    cmd;
	bf_status_t status;

	bf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tlast  (s_axis_tlast),
		.cmd           (cmd),
		.status        (status)
	);

	bf_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.entry_data    (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== rtl/bf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/bf_datapath.sv =====
// Datapath: adjacency matrix store, per-vertex distance state, relax unit, output register.
module bf_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bf_pkg::bf_cmd_t                     cmd,
	output bf_pkg::bf_status_t                  status,
	input  logic [bf_pkg::IN_DATA_BITS-1:0]     entry_data,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [bf_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
	output logic                                m_axis_tlast
);

	import bf_pkg::*;

	// Matrix store
	vidx_t                    entry_row;
	vidx_t                    entry_col;
	weight_t                  entry_weight;
	logic [MAT_ADDR_BITS-1:0] mat_waddr;
	logic [MAT_ADDR_BITS-1:0] mat_raddr;
	weight_t                  weight_s1;
	logic [MAT_DEPTH-1:0]     entry_vld_q;

	// Relaxation stage
	logic  issue_s1;
	logic  vld_s1;
	vidx_t row_s1;
	vidx_t col_s1;
	dist_t da_q;
	logic  ra_q;

	// Per-vertex state
	dist_t                   dist_q [MAX_VERTICES];
	vidx_t                   par_q  [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] reach_q;

	vidx_t rd_addr;
	dist_t db;
	logic  rb;
	vidx_t pb;

	logic                   present;
	logic [DIST_BITS:0]     sum;
	dist_t                  cand;
	logic                   upd;

	// Output register
	logic  out_vld_q;
	vidx_t out_vertex_q;
	logic  out_reach_q;
	dist_t out_dist_q;
	logic  out_has_par_q;
	vidx_t out_par_q;
	logic  out_last_q;

	assign entry_row    = entry_data[VIDX_BITS-1:0];
	assign entry_col    = entry_data[2*VIDX_BITS-1:VIDX_BITS];
	assign entry_weight = entry_data[2*VIDX_BITS+WEIGHT_BITS-1:2*VIDX_BITS];
	assign mat_waddr    = {entry_row, entry_col};
	assign mat_raddr    = {cmd.vtx, cmd.col};

	bf_ram #(
		.WIDTH(WEIGHT_BITS),
		.DEPTH(MAT_DEPTH)
	) u_matrix (
		.clk   (clk),
		.we    (cmd.load_entry),
		.waddr (mat_waddr),
		.wdata (entry_weight),
		.raddr (mat_raddr),
		.rdata (weight_s1)
	);

	// Track written entries; an unwritten entry reads as no edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
		end else if (cmd.load_entry) begin
			entry_vld_q[mat_waddr] <= 1'b1;
		end
	end

	// Stage control for the issued entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		vld_s1 <= entry_vld_q[mat_raddr];
		row_s1 <= cmd.vtx;
		col_s1 <= cmd.col;
	end

	// Single read port on vertex state: relax stage first, else controller vertex
	assign rd_addr = issue_s1 ? col_s1 : cmd.vtx;
	assign db      = dist_q[rd_addr];
	assign rb      = reach_q[rd_addr];
	assign pb      = par_q[rd_addr];

	// Saturating candidate distance and strict less-than test
	assign present = vld_s1 && (weight_s1 != '0);
	assign sum     = {da_q[DIST_BITS-1], da_q}
		+ {{(DIST_BITS+1-WEIGHT_BITS){weight_s1[WEIGHT_BITS-1]}}, weight_s1};

	always_comb begin
		if (sum[DIST_BITS] != sum[DIST_BITS-1]) begin
			cand = sum[DIST_BITS] ? {1'b1, {(DIST_BITS-1){1'b0}}}
				: {1'b0, {(DIST_BITS-1){1'b1}}};
		end else begin
			cand = sum[DIST_BITS-1:0];
		end
	end

	assign upd = issue_s1 && ra_q && present && (!rb || (cand < db));

	// Reached flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= '0;
		end else if (cmd.init) begin
			reach_q <= '0;
			if (cmd.src_ok) begin
				reach_q[cmd.src] <= 1'b1;
			end
		end else if (upd) begin
			reach_q[col_s1] <= 1'b1;
		end
	end

	// Distances and parents
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			dist_q[cmd.src] <= '0;
			par_q[cmd.src]  <= cmd.src;
		end else if (upd) begin
			dist_q[col_s1] <= cand;
			par_q[col_s1]  <= row_s1;
		end
	end

	// Row vertex latch; follow a self-loop update within the row
	always_ff @(posedge clk) begin
		if (cmd.load_row) begin
			da_q <= db;
			ra_q <= rb;
		end else if (upd && (col_s1 == row_s1)) begin
			da_q <= cand;
		end
	end

	// Output register: load on emit, drop on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_vertex_q  <= cmd.vtx;
			out_reach_q   <= rb;
			out_dist_q    <= rb ? db : '0;
			out_has_par_q <= rb;
			out_par_q     <= rb ? pb : '0;
			out_last_q    <= cmd.emit_last;
		end
	end

	assign status.out_ready = !out_vld_q || m_axis_tready;

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = OUT_DATA_BITS'({out_par_q, out_has_par_q, out_dist_q,
		out_reach_q, out_vertex_q});

endmodule

// ===== rtl/bf_ctrl.sv =====
// Controller: configuration registers, load handshake and relaxation/emit sequencing.
module bf_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [bf_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic                               s_axis_tlast,
	output bf_pkg::bf_cmd_t                    cmd,
	input  bf_pkg::bf_status_t                 status
);

	import bf_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INIT  = 3'd1;
	localparam logic [2:0] ST_ROW   = 3'd2;
	localparam logic [2:0] ST_EDGE  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0]          state_q;
	vidx_t               src_cfg_q;
	logic [CNT_BITS-1:0] nv_cfg_q;
	vidx_t               src_q;
	logic [CNT_BITS-1:0] nv_q;
	logic [CNT_BITS-1:0] nv_clamped;
	vidx_t               last_v;
	vidx_t               pass_q;
	vidx_t               a_q;
	vidx_t               b_q;
	vidx_t               k_q;
	logic                accept;
	logic                last_pass;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_cfg_q <= '0;
			nv_cfg_q  <= CNT_BITS'(MAX_VERTICES);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SOURCE_VERTEX:   src_cfg_q <= cfg_wdata[VIDX_BITS-1:0];
				CFG_VERTICES_IN_USE: nv_cfg_q  <= cfg_wdata[CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the vertex count into one to the maximum
	always_comb begin
		if (nv_cfg_q == '0) begin
			nv_clamped = CNT_BITS'(1);
		end else if (nv_cfg_q > CNT_BITS'(MAX_VERTICES)) begin
			nv_clamped = CNT_BITS'(MAX_VERTICES);
		end else begin
			nv_clamped = nv_cfg_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign last_v        = VIDX_BITS'(nv_q - CNT_BITS'(1));
	assign last_pass     = ({1'b0, pass_q} == (nv_q - CNT_BITS'(2)));

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			src_q   <= '0;
			nv_q    <= CNT_BITS'(MAX_VERTICES);
			pass_q  <= '0;
			a_q     <= '0;
			b_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && s_axis_tlast) begin
						src_q   <= src_cfg_q;
						nv_q    <= nv_clamped;
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					pass_q <= '0;
					a_q    <= '0;
					b_q    <= '0;
					k_q    <= '0;
					if (nv_q == CNT_BITS'(1)) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_ROW;
					end
				end
				ST_ROW: begin
					b_q     <= VIDX_BITS'(1);
					state_q <= ST_EDGE;
				end
				ST_EDGE: begin
					if (b_q == last_v) begin
						state_q <= ST_DRAIN;
					end else begin
						b_q <= b_q + VIDX_BITS'(1);
					end
				end
				ST_DRAIN: begin
					b_q <= '0;
					if (a_q == last_v) begin
						a_q <= '0;
						if (last_pass) begin
							state_q <= ST_EMIT;
						end else begin
							pass_q  <= pass_q + VIDX_BITS'(1);
							state_q <= ST_ROW;
						end
					end else begin
						a_q     <= a_q + VIDX_BITS'(1);
						state_q <= ST_ROW;
					end
				end
				ST_EMIT: begin
					if (status.out_ready) begin
						k_q <= k_q + VIDX_BITS'(1);
						if (k_q == last_v) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Commands
	always_comb begin
		cmd            = '0;
		cmd.load_entry = accept;
		cmd.init       = (state_q == ST_INIT);
		cmd.load_row   = (state_q == ST_ROW);
		cmd.issue      = (state_q == ST_ROW) || (state_q == ST_EDGE);
		cmd.emit       = (state_q == ST_EMIT) && status.out_ready;
		cmd.emit_last  = (k_q == last_v);
		cmd.src_ok     = ({1'b0, src_q} < nv_q);
		cmd.vtx        = (state_q == ST_EMIT) ? k_q : a_q;
		cmd.col        = (state_q == ST_ROW) ? '0 : b_q;
		cmd.src        = src_q;
	end

endmodule
